// ----- design/edge_nonmax_suppress_threshold_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the edge suppression core
// ----------------------------------------------------------------------------
`ifndef EDGE_NONMAX_SUPPRESS_THRESHOLD_CORE_DEFINES_SVH
`define EDGE_NONMAX_SUPPRESS_THRESHOLD_CORE_DEFINES_SVH

// same-cycle implication
`define NMS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nmsdt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmsdt_pkg
// Types, register indexes and helpers for the edge suppression core.
// ----------------------------------------------------------------------------
package nmsdt_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int MIN_DIM        = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [7:0]            RST_LOW_THRESH   = 8'd50;
    localparam logic [7:0]            RST_HIGH_THRESH  = 8'd100;

    localparam logic [1:0] DIR_VERT = 2'd0;
    localparam logic [1:0] DIR_HORZ = 2'd1;
    localparam logic [1:0] DIR_D45  = 2'd2;
    localparam logic [1:0] DIR_D135 = 2'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [7:0] EDGE_STRONG = 8'hFF;
    localparam logic [7:0] EDGE_NONE   = 8'h00;

    typedef struct packed {
        logic       cmd;
        logic [7:0] magnitude;
        logic [1:0] direction;
    } t_in_word;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_end;
    } t_out_word;

    // one entry of the line store: magnitudes of the two previous lines
    // and the direction of the previous line at one column
    typedef struct packed {
        logic [7:0] mid;
        logic [7:0] top;
        logic [1:0] dir;
    } t_line_word;

    function automatic logic [7:0] classify(input logic [7:0] v,
                                            input logic [7:0] lo,
                                            input logic [7:0] hi);
        logic [7:0] res;
        if (v >= hi) begin
            res = EDGE_STRONG;
        end else if (v <= lo) begin
            res = EDGE_NONE;
        end else begin
            res = lo;
        end
        return res;
    endfunction

endpackage

// ----- design/edge_nonmax_suppress_threshold_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_nonmax_suppress_threshold_core
// Non-maximum suppression with double threshold on a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_data carries one word per pixel (cmd pixel) or a flush tick (cmd flush).
//   A result word leaves on o_data for every pixel whose window centre is
//   due, and for every flush tick once the frame's last pixel is in; the
//   last result of a frame carries frame_end. Border pixels give 0.
//   Results lag the pixel stream by one line plus one pixel, so a frame
//   needs width+1 flush ticks to drain.
//   Throughput is one word per cycle while the receiver keeps up. The
//   accepting edge latches the line store read and the input word into stage
//   1; when stage 1 advances, the window updates and the result is classified into o_data.
//   The line store is a single RAM (one read and one write port); its
//   registered read sets the two-stage pipeline.
//   When the receiver stalls, the output register holds, stage 1 holds,
//   and o_ready drops as soon as stage 1 cannot drain.
//   Reset (synchronous, active low) restores register defaults, clears
//   counters, window and pipeline; RAM contents are left as they are.
//   Configuration writes on the cfg channel are always taken (o_cfg_ready
//   is high) and must only happen while the block is idle.
// ----------------------------------------------------------------------------
`include "edge_nonmax_suppress_threshold_core_defines.svh"

module edge_nonmax_suppress_threshold_core
    import nmsdt_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_word              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_word             o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // column index / RAM address, effective width, row and height, pixel count
    localparam int WC = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int WH = $clog2(MAX_HEIGHT + 1);
    localparam int WT = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    // clamp the programmed size to the supported range
    function automatic logic [WW-1:0] sat_w(input logic [CFG_DATA_W-1:0] v);
        logic [WW-1:0] res;
        if (32'(v) < MIN_DIM) begin
            res = WW'(MIN_DIM);
        end else if (32'(v) > MAX_WIDTH) begin
            res = WW'(MAX_WIDTH);
        end else begin
            res = WW'(v);
        end
        return res;
    endfunction

    function automatic logic [WH-1:0] sat_h(input logic [CFG_DATA_W-1:0] v);
        logic [WH-1:0] res;
        if (32'(v) < MIN_DIM) begin
            res = WH'(MIN_DIM);
        end else if (32'(v) > MAX_HEIGHT) begin
            res = WH'(MAX_HEIGHT);
        end else begin
            res = WH'(v);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [WW-1:0] r_eff_w;
    logic [WH-1:0] r_eff_h;
    logic [WT-1:0] r_total;
    logic [7:0]    r_low_th;
    logic [7:0]    r_high_th;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w   <= sat_w(RST_IMAGE_WIDTH);
            r_eff_h   <= sat_h(RST_IMAGE_HEIGHT);
            r_total   <= WT'(sat_w(RST_IMAGE_WIDTH)) * WT'(sat_h(RST_IMAGE_HEIGHT));
            r_low_th  <= RST_LOW_THRESH;
            r_high_th <= RST_HIGH_THRESH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_eff_w <= sat_w(i_cfg_data);
                    r_total <= WT'(sat_w(i_cfg_data)) * WT'(r_eff_h);
                end
                CFG_IMAGE_HEIGHT: begin
                    r_eff_h <= sat_h(i_cfg_data);
                    r_total <= WT'(r_eff_w) * WT'(sat_h(i_cfg_data));
                end
                CFG_LOW_THRESHOLD: begin
                    r_low_th <= i_cfg_data[7:0];
                end
                CFG_HIGH_THRESHOLD: begin
                    r_high_th <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, raster counters, line store read
    // ------------------------------------------------------------------
    logic [WC-1:0] r_in_column, n_in_column;
    logic [WH-1:0] r_in_row,    n_in_row;
    logic [WT-1:0] r_out_count, n_out_count;

    logic accept, complete, act_pix, act_flush, s1_load;
    logic col_wrap, pix_emit, pix_interior, flush_last;

    // stage 1 registers
    logic          r_s1_valid;
    logic          r_s1_pix;
    logic          r_s1_emit;
    logic          r_s1_interior;
    logic          r_s1_last;
    logic [7:0]    r_s1_mag;
    logic [1:0]    r_s1_dir;
    logic [WC-1:0] r_s1_ci;
    logic          s1_adv;
    logic          out_free;

    assign out_free = !o_valid || i_ready;
    assign s1_adv   = r_s1_valid && (!r_s1_emit || out_free);
    assign o_ready  = !r_s1_valid || s1_adv;
    assign accept   = i_valid && o_ready;

    assign complete  = r_in_row >= r_eff_h;
    assign act_pix   = accept && (i_data.cmd == CMD_PIXEL) && !complete;
    assign act_flush = accept && (i_data.cmd == CMD_FLUSH) && complete;
    assign s1_load   = act_pix || act_flush;

    assign col_wrap   = ((WW+1)'(r_in_column) + (WW+1)'(1)) >= (WW+1)'(r_eff_w);
    // the window centre sits one line and one pixel behind the input
    assign pix_emit   = (r_in_row >= WH'(2)) ||
                        ((r_in_row == WH'(1)) && (r_in_column >= WC'(1)));
    assign pix_interior = (r_in_row >= WH'(2)) && (r_in_column >= WC'(2)) &&
                          ((WW+1)'(r_in_column) <= ((WW+1)'(r_eff_w) - (WW+1)'(1)));
    assign flush_last = ((WT+1)'(r_out_count) + (WT+1)'(1)) >= (WT+1)'(r_total);

    always_comb begin
        n_in_column = r_in_column;
        n_in_row    = r_in_row;
        n_out_count = r_out_count;
        if (act_pix) begin
            if (col_wrap) begin
                n_in_column = '0;
                n_in_row    = r_in_row + WH'(1);
            end else begin
                n_in_column = r_in_column + WC'(1);
            end
            if (pix_emit) begin
                n_out_count = r_out_count + WT'(1);
            end
        end else if (act_flush) begin
            if (flush_last) begin
                n_in_column = '0;
                n_in_row    = '0;
                n_out_count = '0;
            end else begin
                n_out_count = r_out_count + WT'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_column <= '0;
            r_in_row    <= '0;
            r_out_count <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_in_column <= n_in_column;
            r_in_row    <= n_in_row;
            r_out_count <= n_out_count;
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_pix      <= act_pix;
            r_s1_emit     <= act_flush || pix_emit;
            r_s1_interior <= pix_interior;
            r_s1_last     <= act_flush && flush_last;
            r_s1_mag      <= i_data.magnitude;
            r_s1_dir      <= i_data.direction;
            r_s1_ci       <= r_in_column;
        end
    end

    // ------------------------------------------------------------------
    // Line store RAM: read in stage 0, written back in stage 1.
    // A column is read again only a full line (three words or more) after
    // its write, so no forwarding.
    // ------------------------------------------------------------------
    t_line_word line_mem [MAX_WIDTH];
    t_line_word r_rd;
    t_line_word wr_word;
    logic       mem_we;

    assign mem_we  = s1_adv && r_s1_pix;
    assign wr_word = '{mid: r_s1_mag, top: r_rd.mid, dir: r_s1_dir};

    always_ff @(posedge i_clk) begin
        if (act_pix) begin
            r_rd <= line_mem[r_in_column];
        end
        if (mem_we) begin
            line_mem[r_s1_ci] <= wr_word;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window shift, suppression, thresholds
    // ------------------------------------------------------------------
    logic [7:0] r_win [3][3];
    logic [7:0] nw    [3][3];
    logic [1:0] r_centre_dir;
    logic [7:0] nb_a, nb_b, centre, pix_value;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            nw[r][0] = r_win[r][1];
            nw[r][1] = r_win[r][2];
        end
        nw[0][2] = r_rd.top;
        nw[1][2] = r_rd.mid;
        nw[2][2] = r_s1_mag;
    end

    assign centre = nw[1][1];

    always_comb begin
        case (r_centre_dir)
            DIR_VERT: begin
                nb_a = nw[0][1];
                nb_b = nw[2][1];
            end
            DIR_HORZ: begin
                nb_a = nw[1][0];
                nb_b = nw[1][2];
            end
            DIR_D45: begin
                nb_a = nw[0][0];
                nb_b = nw[2][2];
            end
            default: begin
                nb_a = nw[0][2];
                nb_b = nw[2][0];
            end
        endcase
    end

    // borders and suppressed pixels give no edge
    assign pix_value = (r_s1_interior && (centre > nb_a) && (centre > nb_b)) ?
                       classify(centre, r_low_th, r_high_th) : EDGE_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
            r_centre_dir <= DIR_VERT;
        end else if (mem_we) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= nw[r][c];
                end
            end
            r_centre_dir <= r_rd.dir;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            o_data.edge_value <= r_s1_pix ? pix_value : EDGE_NONE;
            o_data.frame_end  <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `NMS_ASSERT_IMPL(a_mem_no_collide, act_pix && mem_we, r_in_column != r_s1_ci,
        "line store read and write hit the same column")
    `NMS_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_adv,
        r_s1_valid && $stable(r_s1_ci) && $stable(r_s1_emit) && $stable(r_rd.mid),
        "stalled stage 1 lost its contents")
    `NMS_ASSERT_IMPL(a_flush_emits, r_s1_valid && !r_s1_pix, r_s1_emit,
        "flush word in stage 1 without a result")
    `NMS_ASSERT_IMPL(a_frame_end_zero, o_valid && o_data.frame_end,
        o_data.edge_value == EDGE_NONE, "frame end word carries an edge")

endmodule
